>>> hw/rtl/sstf_disk_request_scheduler_top_macros.svh
// Assertion helpers shared by the scheduler's checker.
`ifndef SSTF_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH

// Generic clocked assertion with an active-low reset.
`define SSTF_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define SSTF_ASSERT(name, prop, msg) \
  `SSTF_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

>>> hw/rtl/sstf_pkg.sv
package sstf_pkg;

  localparam int QueueSlotsDef   = 32;
  localparam int CylinderBitsDef = 13;
  localparam int DepthRegW       = 6;
  localparam int CfgDataW        = 13;
  localparam int CfgIdxW         = 1;

  typedef enum logic [CfgIdxW-1:0] {
    RegQueueDepth = 1'b0,
    RegStartCyl   = 1'b1
  } sstf_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StCommit
  } sstf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic fill;      // store the request in the next fill slot
    logic load_req;  // latch the request for a later commit
    logic scan_clr;  // restart the slot scan at slot zero
    logic rd_en;     // read the current scan slot and advance
    logic commit;    // serve the best slot and store the request there
  } sstf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_fill;
    logic scan_last;
  } sstf_sts_t;

endpackage

>>> hw/rtl/sstf_disk_request_scheduler_top.sv
// Shortest-seek-first disk request scheduler. A request is taken on a clock edge
// with start_i high and busy_o low. While the queue is still filling (fewer stored
// requests than the effective depth) a request is stored in the next fill slot, gives no
// result and busy_o stays low. Once the queue is full, each request starts a scan
// of the active slots, one slot read per cycle from the slot memory's single read
// port, followed by a drain state and a commit state. done_o rises at the same edge
// where busy_o falls, and stays high for exactly one cycle; the receiver cannot
// stall it. A new request can be taken in that same cycle. Configuration writes
// take effect at once and are to be made only while busy_o is low and no result
// is pending.
module sstf_disk_request_scheduler_top #(
  parameter int QUEUE_SLOTS   = sstf_pkg::QueueSlotsDef,
  parameter int CYLINDER_BITS = sstf_pkg::CylinderBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sstf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sstf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [CYLINDER_BITS-1:0]      request_cylinder_i,
  output logic                          done_o,
  output logic [CYLINDER_BITS-1:0]      served_cylinder_o,
  output logic [CYLINDER_BITS-1:0]      seek_distance_o
);
  import sstf_pkg::*;

  sstf_cmd_t cmd;
  sstf_sts_t sts;
  sstf_reg_e cfg_reg;

  assign cfg_reg = sstf_reg_e'(cfg_idx_i);

  sstf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  sstf_dp #(
    .QUEUE_SLOTS  (QUEUE_SLOTS),
    .CYLINDER_BITS(CYLINDER_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_reg),
    .cfg_wdata_i       (cfg_wdata_i),
    .request_cylinder_i(request_cylinder_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .done_o            (done_o),
    .served_cylinder_o (served_cylinder_o),
    .seek_distance_o   (seek_distance_o)
  );

endmodule

>>> hw/rtl/sstf_ctrl.sv
module sstf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  sstf_pkg::sstf_sts_t sts_i,
  output sstf_pkg::sstf_cmd_t cmd_o
);
  import sstf_pkg::*;

  sstf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (sts_i.need_fill) begin
            cmd_o.fill = 1'b1;
          end else begin
            cmd_o.load_req = 1'b1;
            cmd_o.scan_clr = 1'b1;
            state_d        = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      // The last slot read is compared here.
      StDrain: begin
        state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

>>> hw/rtl/sstf_dp.sv
module sstf_dp #(
  parameter int QUEUE_SLOTS   = sstf_pkg::QueueSlotsDef,
  parameter int CYLINDER_BITS = sstf_pkg::CylinderBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  sstf_pkg::sstf_reg_e                   cfg_idx_i,
  input  logic [sstf_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic [CYLINDER_BITS-1:0]              request_cylinder_i,
  input  sstf_pkg::sstf_cmd_t                   cmd_i,
  output sstf_pkg::sstf_sts_t                   sts_o,
  output logic                                  done_o,
  output logic [CYLINDER_BITS-1:0]              served_cylinder_o,
  output logic [CYLINDER_BITS-1:0]              seek_distance_o
);
  import sstf_pkg::*;

  localparam int CntW    = $clog2(QUEUE_SLOTS + 1);
  localparam int SlotW   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int DepExtW = DepthRegW + 1;

  logic [DepthRegW-1:0]     depth_q;
  logic [CntW-1:0]          eff_depth;
  logic [CntW-1:0]          fill_q;
  logic [SlotW-1:0]         scan_q;
  logic [CYLINDER_BITS-1:0] head_q;
  logic [CYLINDER_BITS-1:0] req_q;

  logic [CYLINDER_BITS-1:0] slot_mem_q [QUEUE_SLOTS];
  logic [CYLINDER_BITS-1:0] rdata_q;
  logic                     rd_vld_q;
  logic [SlotW-1:0]         rd_idx_q;

  logic [CYLINDER_BITS-1:0] best_cyl_q;
  logic [CYLINDER_BITS-1:0] best_dist_q;
  logic [SlotW-1:0]         best_slot_q;
  logic [CYLINDER_BITS-1:0] seek_dist;
  logic                     take;

  logic                     mem_we;
  logic [SlotW-1:0]         mem_addr;
  logic [CYLINDER_BITS-1:0] mem_wdata;

  logic                     out_vld_q;
  logic [CYLINDER_BITS-1:0] out_cyl_q;
  logic [CYLINDER_BITS-1:0] out_dist_q;

  // A depth of zero acts as one; a depth beyond the queue acts as the full queue.
  always_comb begin
    if (depth_q == '0) begin
      eff_depth = CntW'(1);
    end else if ({1'b0, depth_q} > DepExtW'(QUEUE_SLOTS)) begin
      eff_depth = CntW'(QUEUE_SLOTS);
    end else begin
      eff_depth = CntW'(depth_q);
    end
  end

  assign sts_o.need_fill = (fill_q < eff_depth);
  assign sts_o.scan_last = (CntW'(scan_q) == (eff_depth - CntW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DepthRegW'(1);
      head_q  <= '0;
      fill_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegQueueDepth: depth_q <= cfg_wdata_i[DepthRegW-1:0];
          RegStartCyl:   head_q  <= CYLINDER_BITS'(cfg_wdata_i);
          default: ;
        endcase
      end
      if (cmd_i.fill) begin
        fill_q <= fill_q + CntW'(1);
      end
      if (cmd_i.commit) begin
        head_q <= best_cyl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= request_cylinder_i;
    end
    if (cmd_i.scan_clr) begin
      scan_q <= '0;
    end else if (cmd_i.rd_en) begin
      scan_q <= scan_q + SlotW'(1);
    end
  end

  // One write port for the slot store: fill and commit share it.
  assign mem_we    = cmd_i.fill | cmd_i.commit;
  assign mem_addr  = cmd_i.fill ? fill_q[SlotW-1:0] : best_slot_q;
  assign mem_wdata = cmd_i.fill ? request_cylinder_i : req_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_addr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q  <= slot_mem_q[scan_q];
      rd_idx_q <= scan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.rd_en;
      out_vld_q <= cmd_i.commit;
    end
  end

  assign seek_dist = (rdata_q >= head_q) ? (rdata_q - head_q) : (head_q - rdata_q);
  // Strict less-than keeps the lowest slot on a tie.
  assign take = rd_vld_q && ((rd_idx_q == '0) || (seek_dist < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_cyl_q  <= rdata_q;
      best_dist_q <= seek_dist;
      best_slot_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      out_cyl_q  <= best_cyl_q;
      out_dist_q <= best_dist_q;
    end
  end

  assign done_o            = out_vld_q;
  assign served_cylinder_o = out_cyl_q;
  assign seek_distance_o   = out_dist_q;

endmodule

>>> hw/rtl/sstf_chk.sv
module sstf_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);
  `include "sstf_disk_request_scheduler_top_macros.svh"

  // A result follows the end of a scan, so busy was high the cycle before.
  `SSTF_ASSERT(a_done_after_busy, done_o |-> $past(busy_o), "result without a scan")
  // The block is idle again when the result shows.
  `SSTF_ASSERT(a_done_idle, done_o |-> !busy_o, "busy while a result is shown")
  // A result lasts exactly one cycle.
  `SSTF_ASSERT(a_done_pulse, done_o |=> !done_o, "result held longer than one cycle")
  // A scan only starts from an accepted request.
  `SSTF_ASSERT(a_busy_from_start, $rose(busy_o) |-> $past(start_i), "busy without a request")

endmodule

bind sstf_disk_request_scheduler_top sstf_chk u_sstf_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .done_o (done_o)
);
